// ===== hw/rtl/bsa_pkg.sv =====
// Shared types, constants and codes for the banker's safety allocator.
package bsa_pkg;

  localparam int MAX_PROCS   = 8;
  localparam int MAX_RES     = 8;
  localparam int COUNT_WIDTH = 16;
  localparam int WORK_WIDTH  = 20;
  localparam int PIDX_W      = 3;
  localparam int RIDX_W      = 3;
  localparam int NUM_W       = 4;
  localparam int CFG_IDX_W   = 4;

  typedef logic [COUNT_WIDTH-1:0] cnt_t;
  typedef logic [WORK_WIDTH-1:0]  work_t;
  typedef cnt_t [MAX_RES-1:0]     row_t;
  typedef logic [PIDX_W-1:0]      pidx_t;
  typedef logic [RIDX_W-1:0]      ridx_t;
  typedef logic [NUM_W-1:0]       num_t;

  typedef enum logic [1:0] {
    OP_LOAD_ENTRY = 2'd0,
    OP_LOAD_FREE  = 2'd1,
    OP_REQUEST    = 2'd2,
    OP_CHECK      = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_ACCEPTED = 3'd0,
    ST_GRANTED  = 3'd1,
    ST_DENIED   = 3'd2,
    ST_INVALID  = 3'd3,
    ST_BAD_LOAD = 3'd4
  } status_t;

  localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_COUNT  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESOURCE_COUNT = 4'd1;

  typedef struct packed {
    logic    capture;
    logic    load_entry;
    logic    load_free;
    logic    buf_write;
    logic    buf_clear;
    logic    rd_walk;
    logic    latch_rows;
    logic    grant;
    logic    rollback;
    logic    walk_init;
    logic    walk_step;
    logic    set_result;
    logic    use_count;
    status_t res_status;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic last;
    logic entry_ok;
    logic free_ok;
    logic r_ok;
    logic p_ok;
    logic req_ok;
    logic np_zero;
    logic walk_stop;
    logic safe;
  } sts_t;

endpackage

// ===== hw/rtl/bsa_if.sv =====
// Request, response and configuration channel interfaces.
interface bsa_req_if import bsa_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  pidx_t       process_index;
  ridx_t       resource_index;
  cnt_t        max_value;
  cnt_t        held_value;
  cnt_t        amount;
  logic        last;
  modport source (output valid, operation, process_index, resource_index,
                  max_value, held_value, amount, last, input ready);
  modport sink (input valid, operation, process_index, resource_index,
                max_value, held_value, amount, last, output ready);
endinterface

interface bsa_rsp_if import bsa_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  num_t        finished_count;
  modport source (output valid, status, finished_count, input ready);
  modport sink (input valid, status, finished_count, output ready);
endinterface

interface bsa_cfg_if import bsa_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  num_t                 data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/bankers_safety_allocator_top.sv =====
// Top level of the banker's safety allocator.
// Loads and request elements go through capture and decode; a check adds walk start, the walk
// and resolve, and a request with evaluation adds a claim check before the walk start.
// The safety walk examines one process per cycle, up to P passes of P rows, through the single
// read port of the claim tables.
// One request is worked on at a time; a new one is taken once the previous response is gone.
// Synchronous reset clears tables (through per-entry valid bits), free counts and buffer.
module bankers_safety_allocator_top import bsa_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  bsa_req_if.sink      in_req,
  bsa_rsp_if.source    out_rsp,
  bsa_cfg_if.sink      cfg
);

  num_t    process_count;
  num_t    resource_count;
  num_t    np;
  num_t    nr;
  cmd_t    cmd;
  sts_t    sts;
  status_t res_status;

  assign cfg.ready = 1'b1;
  assign np = (process_count > num_t'(MAX_PROCS)) ? num_t'(MAX_PROCS) : process_count;
  assign nr = (resource_count > num_t'(MAX_RES)) ? num_t'(MAX_RES) : resource_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      process_count  <= num_t'(MAX_PROCS);
      resource_count <= num_t'(MAX_RES);
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_PROCESS_COUNT:  process_count  <= cfg.data;
        CFG_RESOURCE_COUNT: resource_count <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  bsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bsa_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .np             (np),
    .nr             (nr),
    .operation      (in_req.operation),
    .process_index  (in_req.process_index),
    .resource_index (in_req.resource_index),
    .max_value      (in_req.max_value),
    .held_value     (in_req.held_value),
    .amount         (in_req.amount),
    .last           (in_req.last),
    .sts            (sts),
    .res_status     (res_status),
    .res_count      (out_rsp.finished_count)
  );

  assign out_rsp.status = res_status;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_req.valid && in_req.ready) |=> !in_req.ready)
    else $error("request accepted while the previous one is in progress");

  a_no_walk_no_count: assert property (@(posedge clk) disable iff (rst)
    (out_rsp.valid && (out_rsp.status == ST_ACCEPTED || out_rsp.status == ST_INVALID ||
     out_rsp.status == ST_BAD_LOAD)) |-> (out_rsp.finished_count == '0))
    else $error("finished count reported without a safety walk");

  a_ready_blocked_by_rsp: assert property (@(posedge clk) disable iff (rst)
    out_rsp.valid |-> !in_req.ready)
    else $error("request taken while a response is pending");

endmodule

// ===== hw/rtl/bsa_datapath.sv =====
// Datapath: tables, free counts, request buffer and the safety walk registers.
module bsa_datapath import bsa_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       cmd,
  input  num_t       np,
  input  num_t       nr,
  input  logic [1:0] operation,
  input  pidx_t      process_index,
  input  ridx_t      resource_index,
  input  cnt_t       max_value,
  input  cnt_t       held_value,
  input  cnt_t       amount,
  input  logic       last,
  output sts_t       sts,
  output status_t    res_status,
  output num_t       res_count
);

  op_t   op_q;
  pidx_t p_q;
  ridx_t r_q;
  cnt_t  max_q;
  cnt_t  held_q;
  cnt_t  amt_q;
  logic  last_q;

  row_t held_mem [MAX_PROCS];
  row_t need_mem [MAX_PROCS];
  logic [MAX_RES-1:0] vld [MAX_PROCS];

  row_t held_rd;
  row_t need_rd;
  logic [MAX_RES-1:0] vld_rd;
  row_t held_eff;
  row_t need_eff;
  row_t held_old;
  row_t need_old;

  cnt_t  free_cnt [MAX_RES];
  cnt_t  req_buf [MAX_RES];
  work_t work [MAX_RES];
  logic [MAX_PROCS-1:0] marks;
  num_t  count;
  pidx_t cursor;
  pidx_t cursor_next;
  logic  progress;
  pidx_t rd_addr;

  row_t q_m;
  logic [MAX_RES-1:0] lane_on;
  logic  fits;
  logic  req_ok;
  logic  pass_end;
  num_t  count_now;

  always_comb begin
    fits   = !marks[cursor];
    req_ok = 1'b1;
    for (int r = 0; r < MAX_RES; r++) begin
      lane_on[r]  = {1'b0, RIDX_W'(r)} < nr;
      held_eff[r] = vld_rd[r] ? held_rd[r] : '0;
      need_eff[r] = vld_rd[r] ? need_rd[r] : '0;
      q_m[r]      = lane_on[r] ? req_buf[r] : '0;
      if (lane_on[r] && ({4'b0, need_eff[r]} > work[r])) begin
        fits = 1'b0;
      end
      if (q_m[r] > need_eff[r] || q_m[r] > free_cnt[r]) begin
        req_ok = 1'b0;
      end
    end
  end

  assign pass_end  = {1'b0, cursor} == (np - num_t'(1));
  assign count_now = count + num_t'(fits);

  always_comb begin
    if (cmd.walk_init) begin
      cursor_next = '0;
    end else if (cmd.walk_step) begin
      cursor_next = pass_end ? '0 : cursor + pidx_t'(1);
    end else begin
      cursor_next = cursor;
    end
    rd_addr = cmd.rd_walk ? cursor_next : p_q;
  end

  always_comb begin
    sts.op        = op_q;
    sts.last      = last_q;
    sts.r_ok      = {1'b0, r_q} < nr;
    sts.p_ok      = {1'b0, p_q} < np;
    sts.entry_ok  = sts.r_ok && sts.p_ok && (held_q <= max_q);
    sts.free_ok   = sts.r_ok;
    sts.req_ok    = req_ok;
    sts.np_zero   = np == '0;
    sts.walk_stop = pass_end && (!(progress || fits) || (count_now >= np));
    sts.safe      = count >= np;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= op_t'(operation);
      p_q    <= process_index;
      r_q    <= resource_index;
      max_q  <= max_value;
      held_q <= held_value;
      amt_q  <= amount;
      last_q <= last;
    end
    held_rd <= held_mem[rd_addr];
    need_rd <= need_mem[rd_addr];
    if (cmd.latch_rows) begin
      held_old <= held_eff;
      need_old <= need_eff;
    end
    if (cmd.load_entry) begin
      held_mem[p_q][r_q] <= held_q;
      need_mem[p_q][r_q] <= max_q - held_q;
    end
    if (cmd.grant) begin
      for (int r = 0; r < MAX_RES; r++) begin
        held_mem[p_q][r] <= held_eff[r] + q_m[r];
        need_mem[p_q][r] <= need_eff[r] - q_m[r];
      end
    end
    if (cmd.rollback) begin
      held_mem[p_q] <= held_old;
      need_mem[p_q] <= need_old;
    end
    for (int r = 0; r < MAX_RES; r++) begin
      if (cmd.walk_init) begin
        work[r] <= {4'b0, free_cnt[r]};
      end else if (cmd.walk_step && fits) begin
        work[r] <= work[r] + {4'b0, held_eff[r]};
      end
    end
    if (cmd.set_result) begin
      res_status <= cmd.res_status;
      res_count  <= cmd.use_count ? count : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < MAX_PROCS; p++) begin
        vld[p] <= '0;
      end
      vld_rd <= '0;
      for (int r = 0; r < MAX_RES; r++) begin
        free_cnt[r] <= '0;
        req_buf[r]  <= '0;
      end
      marks    <= '0;
      count    <= '0;
      cursor   <= '0;
      progress <= 1'b0;
    end else begin
      vld_rd <= vld[rd_addr];
      if (cmd.load_entry) begin
        vld[p_q][r_q] <= 1'b1;
      end
      if (cmd.grant || cmd.rollback) begin
        vld[p_q] <= '1;
      end
      for (int r = 0; r < MAX_RES; r++) begin
        if (cmd.load_free && (r_q == RIDX_W'(r))) begin
          free_cnt[r] <= amt_q;
        end else if (cmd.grant) begin
          free_cnt[r] <= free_cnt[r] - q_m[r];
        end else if (cmd.rollback) begin
          free_cnt[r] <= free_cnt[r] + q_m[r];
        end
        if (cmd.buf_clear) begin
          req_buf[r] <= '0;
        end else if (cmd.buf_write && (r_q == RIDX_W'(r))) begin
          req_buf[r] <= amt_q;
        end
      end
      cursor <= cursor_next;
      if (cmd.walk_init) begin
        marks    <= '0;
        count    <= '0;
        progress <= 1'b0;
      end else if (cmd.walk_step) begin
        count    <= count_now;
        progress <= pass_end ? 1'b0 : (progress || fits);
        if (fits) begin
          marks[cursor] <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/bsa_ctrl.sv =====
// Controller state machine that sequences loads, requests and the safety walk.
module bsa_ctrl import bsa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_CHECK,
    S_WALK_START,
    S_WALK,
    S_RESOLVE
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = (state == S_IDLE) && !out_valid;
    case (state)
      S_IDLE: begin
        cmd.capture = in_valid && in_ready;
        if (cmd.capture) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next     = S_IDLE;
        cmd.set_result = 1'b1;
        cmd.res_status = ST_ACCEPTED;
        case (sts.op)
          OP_LOAD_ENTRY: begin
            cmd.load_entry = sts.entry_ok;
            if (!sts.entry_ok) begin
              cmd.res_status = ST_BAD_LOAD;
            end
          end
          OP_LOAD_FREE: begin
            cmd.load_free = sts.free_ok;
            if (!sts.free_ok) begin
              cmd.res_status = ST_BAD_LOAD;
            end
          end
          OP_REQUEST: begin
            if (!sts.r_ok) begin
              cmd.buf_clear  = 1'b1;
              cmd.res_status = ST_INVALID;
            end else begin
              cmd.buf_write = 1'b1;
              if (sts.last && !sts.p_ok) begin
                cmd.buf_clear  = 1'b1;
                cmd.res_status = ST_INVALID;
              end else if (sts.last) begin
                cmd.set_result = 1'b0;
                state_next     = S_CHECK;
              end
            end
          end
          default: begin
            cmd.set_result = 1'b0;
            state_next     = S_WALK_START;
          end
        endcase
      end
      S_CHECK: begin
        cmd.latch_rows = 1'b1;
        if (!sts.req_ok) begin
          cmd.buf_clear  = 1'b1;
          cmd.set_result = 1'b1;
          cmd.res_status = ST_INVALID;
          state_next     = S_IDLE;
        end else begin
          cmd.grant  = 1'b1;
          state_next = S_WALK_START;
        end
      end
      S_WALK_START: begin
        cmd.walk_init = 1'b1;
        cmd.rd_walk   = 1'b1;
        state_next    = sts.np_zero ? S_RESOLVE : S_WALK;
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
        cmd.rd_walk   = 1'b1;
        if (sts.walk_stop) begin
          state_next = S_RESOLVE;
        end
      end
      S_RESOLVE: begin
        cmd.set_result = 1'b1;
        cmd.use_count  = 1'b1;
        cmd.res_status = sts.safe ? ST_GRANTED : ST_DENIED;
        if (sts.op == OP_REQUEST) begin
          cmd.buf_clear = 1'b1;
          cmd.rollback  = !sts.safe;
        end
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.set_result) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
